// ===== hdl/ddcmc_pkg.sv =====
// ----------------------------------------------------------------------------
// ddcmc_pkg: shared types and constants of the differential-drive commander
// Frame words, register indexes and the job record passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package ddcmc_pkg;

  localparam logic [10:0] RxId = 11'h581;
  localparam logic [23:0] EncBase = 24'h606443;
  localparam logic [31:0] TxSpeedBase = 32'h0060FF23;
  localparam logic [31:0] TxEncBase = 32'h00606443;
  localparam logic [31:0] TxVbus = 32'h0020354B;
  localparam logic [31:0] TxCtrl = 32'h0060402B;

  // ceil(2^31 / 125): a 24-bit value times this, shifted right by 31, is
  // exactly the value divided by 125.
  localparam logic [24:0] RpmRecip = 25'd17179870;

  localparam logic [2:0] RegWheelBase = 3'd0;
  localparam logic [2:0] RegRpmGain = 3'd1;
  localparam logic [2:0] RegEncCpr = 3'd2;
  localparam logic [2:0] RegDebounce = 3'd3;
  localparam logic [2:0] RegAckTimeout = 3'd4;
  localparam logic [2:0] RegRetryLimit = 3'd5;

  // One tick job: what the back end must emit and compute, with the encoder
  // counts and voltage as they stood when the tick was taken.
  typedef struct packed {
    logic        do_enable;
    logic        do_disable;
    logic        do_speed;
    logic        fault;
    logic        enabled;
    logic [15:0] ms;
    logic signed [31:0] rpm_l;
    logic signed [31:0] rpm_r;
    logic [31:0] cnt0;
    logic [31:0] cnt1;
    logic [15:0] volt;
  } job_t;

endpackage
`default_nettype wire

// ===== hdl/diff_drive_can_motor_commander.sv =====
// ----------------------------------------------------------------------------
// diff_drive_can_motor_commander: CANopen SDO differential-drive commander
// Turns control ticks into SDO frame words and a status word per tick.
// ----------------------------------------------------------------------------
// A tick passes through the front end after it is taken (two multiply steps, a
// reciprocal step for the rpm division, the sequencing step and the hand-over),
// then the back end emits up to seven frame words, one a cycle while the
// receiver is ready, and, when the elapsed time is nonzero, measures each wheel
// in turn with a shift-subtract divider before the status word. The front end
// may take the next tick and received frames while the back end still works.
`default_nettype none
module diff_drive_can_motor_commander
  import ddcmc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: vx_mmps, wz_mradps, elapsed_ms, rx_id, rx_dlc, rx_data_low,
  // rx_data_high, zero fill
  input  wire logic [127:0] s_axis_tdata,
  input  wire logic         s_axis_tuser,   // action
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: data_low, data_high, count_left, count_right, speed_left,
  // speed_right, voltage_raw, enabled, fault, zero fill
  output logic [215:0]      m_axis_tdata,
  output logic              m_axis_tuser,   // kind
  output logic              m_axis_tlast,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic [11:0] wb_q;
  logic [15:0] gain_q, cpr_q, deb_q, ack_q;
  logic [1:0]  lim_q;
  logic        jv, jr;
  job_t        job;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= 12'd300;
      gain_q <= 16'd5849;
      cpr_q <= 16'd4096;
      deb_q <= 16'd200;
      ack_q <= 16'd1000;
      lim_q <= 2'd3;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        RegWheelBase: wb_q <= pwdata[11:0];
        RegRpmGain: gain_q <= pwdata[15:0];
        RegEncCpr: cpr_q <= pwdata[15:0];
        RegDebounce: deb_q <= pwdata[15:0];
        RegAckTimeout: ack_q <= pwdata[15:0];
        RegRetryLimit: lim_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      RegWheelBase: prdata = {20'd0, wb_q};
      RegRpmGain: prdata = {16'd0, gain_q};
      RegEncCpr: prdata = {16'd0, cpr_q};
      RegDebounce: prdata = {16'd0, deb_q};
      RegAckTimeout: prdata = {16'd0, ack_q};
      RegRetryLimit: prdata = {30'd0, lim_q};
      default: prdata = '0;
    endcase
  end

  ddcmc_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .action_i (s_axis_tuser),
    .vx_i (s_axis_tdata[15:0]), .wz_i (s_axis_tdata[31:16]),
    .ms_i (s_axis_tdata[47:32]), .rx_id_i (s_axis_tdata[58:48]),
    .rx_dlc_i (s_axis_tdata[62:59]), .rx_lo_i (s_axis_tdata[94:63]),
    .rx_hi_i (s_axis_tdata[126:95]),
    .track_mm_i (wb_q), .rpm_gain_i (gain_q), .debounce_i (deb_q),
    .ack_timeout_i (ack_q), .retry_limit_i (lim_q),
    .job_valid_o (jv), .job_ready_i (jr), .job_o (job)
  );

  ddcmc_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (jv), .job_ready_o (jr), .job_i (job),
    .cpr_i (cpr_q),
    .out_valid_o (m_axis_tvalid), .out_ready_i (m_axis_tready),
    .out_data_o (m_axis_tdata), .out_last_o (m_axis_tlast)
  );

  assign m_axis_tuser = m_axis_tlast;
endmodule
`default_nettype wire

// ===== hdl/ddcmc_divider.sv =====
// ----------------------------------------------------------------------------
// ddcmc_divider: restoring unsigned divider, one quotient bit per cycle
// Divides a 56-bit dividend by a 32-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module ddcmc_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [55:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             busy_o,
  output logic [55:0]      quot_o
);
  logic [55:0] q_q, q_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] shifted;

  always_comb begin
    q_d = q_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    shifted = {rem_q[31:0], q_q[55]};
    if (start_i) begin
      q_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = 6'd55;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = shifted - {1'b0, dvs_q};
        q_d = {q_q[54:0], 1'b1};
      end else begin
        rem_d = shifted;
        q_d = {q_q[54:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = q_q;
endmodule
`default_nettype wire

// ===== hdl/ddcmc_front.sv =====
// ----------------------------------------------------------------------------
// ddcmc_front: accepts words, handles received frames, sequences the drive
// Works out the wheel commands in steps and posts one job per tick.
// ----------------------------------------------------------------------------
`default_nettype none
module ddcmc_front
  import ddcmc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [15:0] vx_i,
  input  wire logic [15:0] wz_i,
  input  wire logic [15:0] ms_i,
  input  wire logic [10:0] rx_id_i,
  input  wire logic [3:0]  rx_dlc_i,
  input  wire logic [31:0] rx_lo_i,
  input  wire logic [31:0] rx_hi_i,
  input  wire logic [11:0] track_mm_i,
  input  wire logic [15:0] rpm_gain_i,
  input  wire logic [15:0] debounce_i,
  input  wire logic [15:0] ack_timeout_i,
  input  wire logic [1:0]  retry_limit_i,
  output logic             job_valid_o,
  input  wire logic        job_ready_i,
  output job_t             job_o
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_MUL1 = 6'b000010, S_MUL2 = 6'b000100,
    S_REC = 6'b001000, S_DIV = 6'b010000, S_POST = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] cnt0_q, cnt1_q;
  logic [15:0] volt_q;
  logic        on_q, on_d, await_q, await_d;
  logic [1:0]  retries_q, retries_d;
  logic [15:0] since_q, since_d;
  logic        en_q, en_d, dis_q, dis_d, flt_q, flt_d;
  logic signed [15:0] vx_q, wz_q;
  logic [15:0] ms_q;
  logic signed [31:0] sl_q, sr_q;
  logic signed [48:0] pl_q, pr_q;
  logic [48:0] rl_q, rr_q;
  logic signed [31:0] rpm_l_q, rpm_r_q;

  logic signed [28:0] wzb;
  logic signed [27:0] vx2k;
  logic signed [48:0] ql, qr;
  logic        want;
  logic [16:0] since_sum;
  logic [15:0] since_sat;
  logic [2:0]  next_r;
  logic        fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign fire = in_valid_i && in_ready_o;
  assign wzb = wz_q * $signed({1'b0, track_mm_i});
  assign vx2k = vx_q * $signed(13'sd2000);
  // Division by 2000*65536 = 125*2^20 truncating toward zero: the magnitude
  // is shifted right by 20, then divided by 125 through a reciprocal product.
  // Nested floors of the magnitude equal the direct one.
  logic [47:0] ml, mr;
  assign ml = pl_q[48] ? 48'(-pl_q) : pl_q[47:0];
  assign mr = pr_q[48] ? 48'(-pr_q) : pr_q[47:0];
  logic [31:0] dl, dr;
  assign dl = 32'(rl_q[48:31]);
  assign dr = 32'(rr_q[48:31]);
  assign ql = pl_q[48] ? -49'(dl) : 49'(dl);
  assign qr = pr_q[48] ? -49'(dr) : 49'(dr);

  always_comb begin
    since_sum = {1'b0, since_q} + {1'b0, ms_q};
    since_sat = since_sum[16] ? 16'hFFFF : since_sum[15:0];
    want = (sl_q != 0) || (sr_q != 0);
    next_r = {1'b0, retries_q} + 3'd1;
    since_d = since_sat;
    on_d = on_q;
    await_d = await_q;
    retries_d = retries_q;
    en_d = 1'b0;
    dis_d = 1'b0;
    flt_d = 1'b0;
    if (want != on_q) begin
      if (!await_q && since_sat >= debounce_i) begin
        await_d = 1'b1;
        since_d = '0;
        on_d = want;
        en_d = want;
        dis_d = !want;
      end else if (await_q && since_sat >= ack_timeout_i) begin
        await_d = 1'b0;
        if (next_r < {1'b0, retry_limit_i}) retries_d = next_r[1:0];
        else begin
          retries_d = '0;
          flt_d = 1'b1;
        end
      end
    end else if (await_q) begin
      await_d = 1'b0;
      retries_d = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (fire && !action_i) state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_REC;
      S_REC: state_d = S_DIV;
      S_DIV: state_d = S_POST;
      S_POST: if (job_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt0_q <= '0;
      cnt1_q <= '0;
      volt_q <= '0;
      on_q <= 1'b0;
      await_q <= 1'b0;
      retries_q <= '0;
      since_q <= '0;
      en_q <= 1'b0;
      dis_q <= 1'b0;
      flt_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire && action_i && rx_id_i == RxId && rx_dlc_i >= 4'd8) begin
        if (rx_lo_i[23:0] == EncBase) begin
          if (rx_lo_i[31:24] == 8'd1) cnt0_q <= rx_hi_i;
          else if (rx_lo_i[31:24] == 8'd2) cnt1_q <= rx_hi_i;
        end else if (rx_lo_i == TxVbus) begin
          volt_q <= rx_hi_i[15:0];
        end
      end
      if (state_q == S_DIV) begin
        since_q <= since_d;
        on_q <= on_d;
        await_q <= await_d;
        retries_q <= retries_d;
        en_q <= en_d;
        dis_q <= dis_d;
        flt_q <= flt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      vx_q <= vx_i;
      wz_q <= wz_i;
      ms_q <= ms_i;
    end
    if (state_q == S_MUL1) begin
      sl_q <= 32'(vx2k) - 32'(wzb);
      sr_q <= 32'(vx2k) + 32'(wzb);
    end
    if (state_q == S_MUL2) begin
      pl_q <= sl_q * $signed({1'b0, rpm_gain_i});
      pr_q <= sr_q * $signed({1'b0, rpm_gain_i});
    end
    if (state_q == S_REC) begin
      rl_q <= {25'd0, ml[43:20]} * {24'd0, RpmRecip};
      rr_q <= {25'd0, mr[43:20]} * {24'd0, RpmRecip};
    end
    if (state_q == S_DIV) begin
      rpm_l_q <= 32'(ql);
      rpm_r_q <= 32'(-qr);
    end
  end

  // Counts, voltage and drive state stay put while the job is posted, as no
  // word is taken outside the idle state.
  always_comb begin
    job_o.do_enable = en_q;
    job_o.do_disable = dis_q;
    job_o.do_speed = on_q && !await_q;
    job_o.fault = flt_q;
    job_o.enabled = on_q;
    job_o.ms = ms_q;
    job_o.rpm_l = rpm_l_q;
    job_o.rpm_r = rpm_r_q;
    job_o.cnt0 = cnt0_q;
    job_o.cnt1 = cnt1_q;
    job_o.volt = volt_q;
  end
  assign job_valid_o = (state_q == S_POST);
endmodule
`default_nettype wire

// ===== hdl/ddcmc_back.sv =====
// ----------------------------------------------------------------------------
// ddcmc_back: emits the frame words and the status word of one tick
// Measures both wheel speeds through the shared divider when the tick's elapsed time is nonzero.
// ----------------------------------------------------------------------------
`default_nettype none
module ddcmc_back
  import ddcmc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  output logic             job_ready_o,
  input  job_t             job_i,
  input  wire logic [15:0] cpr_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [215:0]     out_data_o,
  output logic             out_last_o
);
  typedef enum logic [5:0] {
    B_IDLE = 6'b000001, B_EMIT = 6'b000010, B_MUL = 6'b000100,
    B_DIV = 6'b001000, B_WAIT = 6'b010000, B_STAT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  job_t   job_q;
  logic [3:0] seq_q;
  logic       axis_q;
  logic [31:0] prev0_q, prev1_q, spd0_q, spd1_q;
  logic [31:0] den_q;
  logic        neg_q;
  logic [55:0] num_q;
  logic        dstart;
  logic        dbusy;
  logic [55:0] quot;
  logic [31:0] delta;
  logic [31:0] mag;
  logic [15:0] cpr;
  logic [31:0] sat;
  logic [63:0] frame;
  logic        frame_ok;

  assign job_ready_o = (state_q == B_IDLE);

  // Frame list: 0..3 enable, 4..6 disable, 7..8 speed, 9..11 requests.
  always_comb begin
    frame = '0;
    frame_ok = 1'b1;
    case (seq_q)
      4'd0: frame = {32'h0, TxCtrl};
      4'd1: frame = {32'h6, TxCtrl};
      4'd2: frame = {32'h7, TxCtrl};
      4'd3: frame = {32'hF, TxCtrl};
      4'd4: frame = {32'h0, TxSpeedBase | 32'h01000000};
      4'd5: frame = {32'h0, TxSpeedBase | 32'h02000000};
      4'd6: frame = {32'h0, TxCtrl};
      4'd7: frame = {job_q.rpm_l, TxSpeedBase | 32'h01000000};
      4'd8: frame = {job_q.rpm_r, TxSpeedBase | 32'h02000000};
      4'd9: frame = {32'h0, TxEncBase | 32'h01000000};
      4'd10: frame = {32'h0, TxEncBase | 32'h02000000};
      4'd11: frame = {32'h0, TxVbus};
      default: frame_ok = 1'b0;
    endcase
  end

  function automatic logic [3:0] next_seq(input logic [3:0] s, input job_t j);
    logic [3:0] n;
    begin
      n = s + 4'd1;
      if (s == 4'd3) n = j.do_speed ? 4'd7 : 4'd9;
      if (s == 4'd6) n = j.do_speed ? 4'd7 : 4'd9;
      return n;
    end
  endfunction

  assign cpr = (cpr_i == 16'd0) ? 16'd1 : cpr_i;
  assign delta = axis_q ? (job_q.cnt1 - prev1_q) : (job_q.cnt0 - prev0_q);
  assign mag = delta[31] ? 32'(-delta) : delta;

  always_comb begin
    if (quot > 56'h7FFFFFFF) sat = neg_q ? 32'h80000000 : 32'h7FFFFFFF;
    else sat = neg_q ? 32'(-quot[31:0]) : quot[31:0];
  end

  assign dstart = (state_q == B_MUL);

  ddcmc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dstart),
    .dividend_i (num_q),
    .divisor_i  (den_q),
    .busy_o     (dbusy),
    .quot_o     (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (job_valid_i) state_d = B_EMIT;
      B_EMIT: if (out_ready_i && seq_q == 4'd11)
        state_d = (job_q.ms == 16'd0) ? B_STAT : B_DIV;
      B_DIV: state_d = B_MUL;
      B_MUL: state_d = B_WAIT;
      B_WAIT: if (!dbusy) state_d = axis_q ? B_STAT : B_DIV;
      B_STAT: if (out_ready_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      seq_q <= '0;
      axis_q <= 1'b0;
      prev0_q <= '0;
      prev1_q <= '0;
      spd0_q <= '0;
      spd1_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_IDLE && job_valid_i) begin
        seq_q <= job_i.do_enable ? 4'd0 : job_i.do_disable ? 4'd4 :
                 job_i.do_speed ? 4'd7 : 4'd9;
        axis_q <= 1'b0;
      end
      if (state_q == B_EMIT && out_ready_i) seq_q <= next_seq(seq_q, job_q);
      if (state_q == B_WAIT && !dbusy) begin
        if (axis_q) begin
          spd1_q <= sat;
          prev1_q <= job_q.cnt1;
        end else begin
          spd0_q <= sat;
          prev0_q <= job_q.cnt0;
        end
        axis_q <= 1'b1;
      end
    end
  end

  // Two products, |delta|*6000000 and cpr*ms, registered together in the same step.
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && job_valid_i) job_q <= job_i;
    if (state_q == B_DIV) begin
      num_q <= 56'(mag) * 56'd6000000;
      den_q <= 32'(cpr) * 32'(job_q.ms);
      neg_q <= delta[31];
    end
  end

  assign out_valid_o = (state_q == B_EMIT && frame_ok) || (state_q == B_STAT);
  assign out_last_o = (state_q == B_STAT);
  always_comb begin
    if (state_q == B_STAT)
      out_data_o = {6'd0, job_q.fault, job_q.enabled, job_q.volt, spd1_q, spd0_q,
                    job_q.cnt1, job_q.cnt0, 64'd0};
    else
      out_data_o = {152'd0, frame};
  end
endmodule
`default_nettype wire

// ===== tb/ddcmc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddcmc_checker: result checker for the differential-drive commander
// Watches the input, output and register channels, keeps its own copy of the
// commander state, predicts every frame and status word of a tick and compares
// them field by field in order.
// ----------------------------------------------------------------------------
module ddcmc_checker
  import ddcmc_pkg::*;
#(
  parameter int DataW = 216
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  input  wire logic             s_axis_tready,
  input  wire logic [127:0]     s_axis_tdata,
  input  wire logic             s_axis_tuser,
  input  wire logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  input  wire logic [DataW-1:0] m_axis_tdata,
  input  wire logic             m_axis_tuser,
  input  wire logic             m_axis_tlast,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  input  wire logic             pready,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic        kind;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] cnt_l;
    logic [31:0] cnt_r;
    logic [31:0] spd_l;
    logic [31:0] spd_r;
    logic [15:0] volt;
    logic        en;
    logic        flt;
    logic        last;
  } word_t;

  word_t expected_words[$];

  // Register copy.
  logic [11:0] track_mm;
  logic [15:0] gain, cpr, debounce, ack_timeout;
  logic [1:0]  retry_max;
  // Commander state copy.
  logic [31:0] wheel_cnt[2], prev_cnt[2], meas_spd[2];
  logic [15:0] vbus;
  logic        drive_on, awaiting;
  logic [1:0]  retries;
  logic [15:0] since_change;

  function automatic word_t frame_word(logic [31:0] lo, logic [31:0] hi);
    word_t w;
    w = '0;
    w.lo = lo;
    w.hi = hi;
    return w;
  endfunction

  task automatic add_expected(word_t w);
    expected_words = {expected_words, w};
  endtask

  task automatic take_frame(logic [127:0] d);
    logic [10:0] id;
    logic [3:0]  dlc;
    logic [31:0] lo, hi;
    id  = d[58:48];
    dlc = d[62:59];
    lo  = d[94:63];
    hi  = d[126:95];
    if (id == RxId && dlc >= 4'd8) begin
      if (lo[23:0] == EncBase) begin
        if (lo[31:24] == 8'd1) wheel_cnt[0] = hi;
        else if (lo[31:24] == 8'd2) wheel_cnt[1] = hi;
      end else if (lo == TxVbus) begin
        vbus = hi[15:0];
      end
    end
  endtask

  task automatic predict_tick(logic [127:0] d);
    longint vx, wz, s_l, s_r, rpm_l, rpm_r, sum, delta, q, div;
    logic [15:0] ms;
    logic [31:0] dw;
    logic want, flt;
    word_t st;
    vx = longint'($signed(d[15:0]));
    wz = longint'($signed(d[31:16]));
    ms = d[47:32];
    s_l = 2000 * vx - wz * longint'(track_mm);
    s_r = 2000 * vx + wz * longint'(track_mm);
    rpm_l = (s_l * longint'(gain)) / 64'sd131072000;
    rpm_r = -((s_r * longint'(gain)) / 64'sd131072000);
    want = (s_l != 0) || (s_r != 0);
    flt = 1'b0;
    sum = longint'(since_change) + longint'(ms);
    since_change = (sum > 65535) ? 16'hFFFF : sum[15:0];
    if (want != drive_on) begin
      if (!awaiting && since_change >= debounce) begin
        awaiting = 1'b1;
        since_change = '0;
        if (want) begin
          add_expected(frame_word(TxCtrl, 32'h00));
          add_expected(frame_word(TxCtrl, 32'h06));
          add_expected(frame_word(TxCtrl, 32'h07));
          add_expected(frame_word(TxCtrl, 32'h0F));
          drive_on = 1'b1;
        end else begin
          add_expected(frame_word(TxSpeedBase | (32'd1 << 24), '0));
          add_expected(frame_word(TxSpeedBase | (32'd2 << 24), '0));
          add_expected(frame_word(TxCtrl, 32'h00));
          drive_on = 1'b0;
        end
      end else if (awaiting && since_change >= ack_timeout) begin
        awaiting = 1'b0;
        if ({1'b0, retries} + 3'd1 < {1'b0, retry_max}) begin
          retries = retries + 2'd1;
        end else begin
          retries = '0;
          flt = 1'b1;
        end
      end
    end else if (awaiting) begin
      awaiting = 1'b0;
      retries = '0;
    end
    if (drive_on && !awaiting) begin
      add_expected(frame_word(TxSpeedBase | (32'd1 << 24), rpm_l[31:0]));
      add_expected(frame_word(TxSpeedBase | (32'd2 << 24), rpm_r[31:0]));
    end
    add_expected(frame_word(TxEncBase | (32'd1 << 24), '0));
    add_expected(frame_word(TxEncBase | (32'd2 << 24), '0));
    add_expected(frame_word(TxVbus, '0));
    // With no elapsed time the measured speeds and previous counts stand.
    if (ms != 0) begin
      div = (cpr == 0 ? 64'sd1 : longint'(cpr)) * longint'(ms);
      for (int i = 0; i < 2; i++) begin
        dw = wheel_cnt[i] - prev_cnt[i];
        delta = longint'($signed(dw));
        q = (delta * 64'sd6000000) / div;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        meas_spd[i] = q[31:0];
        prev_cnt[i] = wheel_cnt[i];
      end
    end
    st = '0;
    st.kind = 1'b1;
    st.cnt_l = wheel_cnt[0];
    st.cnt_r = wheel_cnt[1];
    st.spd_l = meas_spd[0];
    st.spd_r = meas_spd[1];
    st.volt = vbus;
    st.en = drive_on;
    st.flt = flt;
    st.last = 1'b1;
    add_expected(st);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic check_word();
    word_t e;
    logic [215:0] d;
    d = '0;
    d[DataW-1:0] = m_axis_tdata;
    if (expected_words.size() == 0) begin
      report_mismatch("unexpected word, data_low", d[31:0], '0);
      return;
    end
    e = expected_words.pop_front();
    if (m_axis_tuser !== e.kind) report_mismatch("kind", m_axis_tuser, e.kind);
    if (m_axis_tlast !== e.last) report_mismatch("last", m_axis_tlast, e.last);
    if (d[31:0] !== e.lo) report_mismatch("data_low", d[31:0], e.lo);
    if (d[63:32] !== e.hi) report_mismatch("data_high", d[63:32], e.hi);
    if (d[95:64] !== e.cnt_l) report_mismatch("count_left", d[95:64], e.cnt_l);
    if (d[127:96] !== e.cnt_r) report_mismatch("count_right", d[127:96], e.cnt_r);
    if (d[159:128] !== e.spd_l) report_mismatch("speed_left", d[159:128], e.spd_l);
    if (d[191:160] !== e.spd_r) report_mismatch("speed_right", d[191:160], e.spd_r);
    if (d[207:192] !== e.volt) report_mismatch("voltage_raw", d[207:192], e.volt);
    // The flag bits lie above the voltage, where the port is wide enough.
    if (DataW > 208 && d[208] !== e.en) report_mismatch("enabled", d[208], e.en);
    if (DataW > 209 && d[209] !== e.flt) report_mismatch("fault", d[209], e.flt);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_mm     = 12'd300;
      gain         = 16'd5849;
      cpr          = 16'd4096;
      debounce     = 16'd200;
      ack_timeout  = 16'd1000;
      retry_max    = 2'd3;
      wheel_cnt    = '{default: '0};
      prev_cnt     = '{default: '0};
      meas_spd     = '{default: '0};
      vbus         = '0;
      drive_on     = 1'b0;
      awaiting     = 1'b0;
      retries      = '0;
      since_change = '0;
      expected_words.delete();
      pending_o   <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegWheelBase:  track_mm    = pwdata[11:0];
          RegRpmGain:    gain        = pwdata[15:0];
          RegEncCpr:     cpr         = pwdata[15:0];
          RegDebounce:   debounce    = pwdata[15:0];
          RegAckTimeout: ack_timeout = pwdata[15:0];
          RegRetryLimit: retry_max   = pwdata[1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) take_frame(s_axis_tdata);
        else predict_tick(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) check_word();
      pending_o <= expected_words.size();
    end
  end

  initial fail_count_o = 0;

endmodule

// ===== tb/diff_drive_can_motor_commander_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_can_motor_commander_test: top of the commander testbench
// Drives ticks and received frames with random gaps, changes the registers
// between phases and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module diff_drive_can_motor_commander_test;
  import ddcmc_pkg::*;

  localparam int DataW = 216;
  localparam longint CycleLimit = 3000000;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [127:0]     s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [DataW-1:0] m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tlast;
  logic             psel, penable, pwrite;
  logic [4:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  int               fail_count, pending;
  int               hold_off;
  logic             hold_req, hold_ack;
  longint           cycles;

  diff_drive_can_motor_commander dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ddcmc_checker #(.DataW(DataW)) checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: short random stalls, now and then a long one, and a long
  // hold-off whenever the stimulus toggles its request.
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_off <= 600;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      hold_off <= $urandom_range(20, 120);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // The sender stops offering, then waits for every expected word.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_word(logic action, logic [127:0] data);
    int gap;
    logic ok;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= action;
    s_axis_tdata <= data;
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) :
          ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_tick(logic [15:0] vx, logic [15:0] wz, logic [15:0] ms);
    send_word(1'b0, {80'b0, ms, wz, vx});
  endtask

  task automatic send_frame(logic [10:0] id, logic [3:0] dlc, logic [31:0] lo,
                            logic [31:0] hi);
    send_word(1'b1, {1'b0, hi, lo, dlc, id, 48'b0});
  endtask

  task automatic random_tick();
    logic [15:0] vx, wz, ms;
    int sel;
    sel = $urandom_range(0, 9);
    vx = (sel < 4) ? 16'd0 : (sel < 8) ? 16'($signed($urandom_range(0, 4000)) - 2000)
                                       : 16'($urandom);
    wz = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
    if (sel < 3) wz = 16'd0;
    ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    send_tick(vx, wz, ms);
  endtask

  task automatic random_frame();
    logic [31:0] lo, hi;
    int sel;
    sel = $urandom_range(0, 9);
    hi = ($urandom_range(0, 1) == 0) ? 32'($urandom) : 32'($urandom_range(0, 20000));
    if (sel < 6) lo = TxEncBase | (32'($urandom_range(1, 2)) << 24);
    else if (sel < 8) lo = TxVbus;
    else lo = $urandom;
    if ($urandom_range(0, 7) == 0)
      send_frame(11'($urandom), 4'($urandom), lo, hi);
    else
      send_frame(RxId, 4'($urandom_range(8, 15)), lo, hi);
  endtask

  task automatic random_phase(int count);
    int done;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 2) == 0) begin
        random_frame();
      end else begin
        random_tick();
        done++;
      end
    end
  endtask

  initial begin
    cycles = 0;
    hold_off = 0;
    hold_req = 1'b0;
    hold_ack = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part under the reset settings.
    send_tick(16'd0, 16'd0, 16'd0);
    send_tick(16'h7FFF, 16'h7FFF, 16'd250);
    send_tick(16'h8000, 16'h8000, 16'd100);
    send_tick(16'h7FFF, 16'h8000, 16'hFFFF);
    send_frame(RxId, 4'd8, TxEncBase | (32'd1 << 24), 32'h7FFF_FFFF);
    send_frame(RxId, 4'd15, TxEncBase | (32'd2 << 24), 32'h8000_0000);
    send_frame(RxId, 4'd8, TxEncBase | (32'd3 << 24), 32'h1234_5678);
    send_frame(RxId, 4'd7, TxVbus, 32'h0000_1111);
    send_frame(11'h582, 4'd8, TxVbus, 32'h0000_2222);
    send_frame(RxId, 4'd8, TxVbus, 32'hFFFF_FFFF);
    send_tick(16'd100, 16'd0, 16'd1);
    send_tick(16'd100, 16'd0, 16'd0);
    send_tick(16'd0, 16'd0, 16'd1200);
    send_tick(16'd0, 16'd0, 16'd300);
    send_tick(16'd0, 16'd5, 16'd1100);
    send_tick(16'd0, 16'd0, 16'd1100);
    send_tick(16'd0, 16'd0, 16'd1100);
    send_tick(16'd0, 16'd0, 16'd1100);
    send_frame(11'h7FF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_frame(11'h000, 4'h0, 32'h0, 32'h0);
    drain();

    // Extremes with no debounce and an immediate timeout.
    write_reg(RegWheelBase, 32'd4095);
    write_reg(RegRpmGain, 32'd65535);
    write_reg(RegEncCpr, 32'd1);
    write_reg(RegDebounce, 32'd0);
    write_reg(RegAckTimeout, 32'd0);
    write_reg(RegRetryLimit, 32'd1);
    send_tick(16'h7FFF, 16'h8000, 16'd1);
    random_phase(70);

    // Let the output back up while ticks keep coming.
    hold_req <= ~hold_req;
    random_phase(15);
    drain();

    write_reg(RegWheelBase, 32'd1);
    write_reg(RegRpmGain, 32'd1);
    write_reg(RegEncCpr, 32'd65535);
    write_reg(RegDebounce, 32'd65535);
    write_reg(RegAckTimeout, 32'd65535);
    write_reg(RegRetryLimit, 32'd3);
    random_phase(60);
    drain();

    write_reg(RegWheelBase, 32'd520);
    write_reg(RegRpmGain, 32'd9000);
    write_reg(RegEncCpr, 32'd1000);
    write_reg(RegDebounce, 32'd40);
    write_reg(RegAckTimeout, 32'd150);
    write_reg(RegRetryLimit, 32'd2);
    random_phase(85);
    drain();

    write_reg(RegWheelBase, 32'($urandom_range(1, 4095)));
    write_reg(RegRpmGain, 32'($urandom_range(1, 65535)));
    write_reg(RegEncCpr, 32'($urandom_range(1, 65535)));
    write_reg(RegDebounce, 32'($urandom_range(0, 300)));
    write_reg(RegAckTimeout, 32'($urandom_range(0, 600)));
    write_reg(RegRetryLimit, 32'($urandom_range(1, 3)));
    random_phase(75);

    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
